FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, pre, post, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`define ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

FILE: hdl/kqt_pkg.sv
// ---------------------------------------------------------------------------
// kqt_pkg
// Shared types and constants of the keyed quantity table.
// ---------------------------------------------------------------------------
`default_nettype none
package kqt_pkg;

  localparam int KQT_ENTRIES = 32;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 24;
  localparam int TOTAL_W = 29;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } kqt_cmd_t;

  // The request walks the chain twice: once to look for the key, once to act.
  typedef enum logic [1:0] {
    PH_SCAN  = 2'b01,
    PH_APPLY = 2'b10
  } kqt_phase_t;

  typedef struct packed {
    logic               active;
    kqt_phase_t         phase;
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] qty;
    logic               found;
    logic               done;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
  } kqt_wave_t;

endpackage
`default_nettype wire

FILE: hdl/kqt_cell.sv
// ---------------------------------------------------------------------------
// kqt_cell
// One table slot: holds a key and a count, and updates them as the request
// passes through, handing the request on to the next slot through its output register.
// ---------------------------------------------------------------------------
`default_nettype none
module kqt_cell
  import kqt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire kqt_wave_t wave_in,
  output kqt_wave_t      wave_out
);

  logic [KEY_W-1:0]   ekey;
  logic [COUNT_W-1:0] ecount;
  logic               evalid;

  logic [KEY_W-1:0]   ekey_next;
  logic [COUNT_W-1:0] ecount_next;
  logic               evalid_next;
  kqt_wave_t          wave_next;
  kqt_wave_t          wave_next_total_fix;

  logic               match;
  logic [COUNT_W:0]   add_sum;
  logic [COUNT_W-1:0] add_sat;
  logic [COUNT_W-1:0] addend;
  logic [TOTAL_W:0]   tot_sum;

  assign match   = evalid && (ekey == wave_in.key);
  assign add_sum = {1'b0, ecount} + {1'b0, wave_in.qty};
  assign add_sat = add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];

  always_comb begin
    wave_next   = wave_in;
    ekey_next   = ekey;
    ecount_next = ecount;
    evalid_next = evalid;
    if (wave_in.active && wave_in.phase == PH_SCAN) begin
      wave_next.found = wave_in.found | match;
    end
    if (wave_in.active && wave_in.phase == PH_APPLY) begin
      if (match && !wave_in.done) begin
        wave_next.done = 1'b1;
        case (wave_in.cmd)
          CMD_ADD: begin
            ecount_next     = add_sat;
            wave_next.count = add_sat;
          end
          CMD_REMOVE: begin
            if (wave_in.qty < ecount) begin
              ecount_next     = ecount - wave_in.qty;
              wave_next.count = ecount - wave_in.qty;
            end else begin
              evalid_next     = 1'b0;
              wave_next.count = '0;
            end
          end
          default: begin
            wave_next.count = ecount;
          end
        endcase
      end else if (wave_in.cmd == CMD_ADD && !wave_in.found && !wave_in.done &&
                   !evalid) begin
        // First free slot takes the new key.
        ekey_next       = wave_in.key;
        ecount_next     = wave_in.qty;
        evalid_next     = 1'b1;
        wave_next.done  = 1'b1;
        wave_next.count = wave_in.qty;
      end
    end
  end

  // The total is gathered from the slot contents as they will be after this op.
  assign addend  = evalid_next ? ecount_next : '0;
  assign tot_sum = {1'b0, wave_in.total} + {{(TOTAL_W-COUNT_W+1){1'b0}}, addend};

  always_comb begin
    wave_next_total_fix = wave_next;
    if (wave_in.phase == PH_APPLY) begin
      wave_next_total_fix.total = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    ekey   <= ekey_next;
    ecount <= ecount_next;
    if (rst) begin
      evalid   <= 1'b0;
      wave_out <= '0;
    end else begin
      evalid   <= evalid_next;
      wave_out <= wave_next_total_fix;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/keyed_quantity_table.sv
// ---------------------------------------------------------------------------
// keyed_quantity_table
// Associative (key, count) table with add, remove and query requests.
// ---------------------------------------------------------------------------
// The table is a chain of ENTRIES slot cells. A request with a nonzero key
// walks the chain twice, one cell per clock: a scan pass that finds out
// whether the key is present, then an apply pass that updates the matching
// slot (or fills the lowest free slot on an add) and sums the counts. One
// request is handled at a time; when the apply pass leaves the chain its
// result is registered as pending, then loaded into the output registers
// once the output is free. A request with key zero changes nothing; its
// result is registered as pending on acceptance, with the running total.
// A response may wait at the output while the next request is taken in.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module keyed_quantity_table
  import kqt_pkg::*;
#(
  parameter int ENTRIES = KQT_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [KEY_W-1:0]   key,
  input  wire logic [COUNT_W-1:0] quantity,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic [COUNT_W-1:0]      count,
  output logic                    found,
  output logic                    table_full,
  output logic [TOTAL_W-1:0]      total_quantity
);

  kqt_wave_t wave [ENTRIES+1];
  logic [ENTRIES:0] act;

  kqt_wave_t head;
  kqt_wave_t head_next;
  kqt_wave_t tail;

  logic busy;
  logic [TOTAL_W-1:0] running_total;

  logic               res_pend;
  logic [COUNT_W-1:0] res_count;
  logic               res_found;
  logic               res_full;
  logic [TOTAL_W-1:0] res_total;

  logic accept;
  logic tail_scan;
  logic tail_apply;
  logic load_out;

  assign wave[0] = head;
  assign tail    = wave[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kqt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (wave[i]),
      .wave_out (wave[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_act
    assign act[i] = wave[i].active;
  end

  assign req_ready  = !busy && !res_pend;
  assign accept     = req_valid && req_ready;
  assign tail_scan  = tail.active && tail.phase == PH_SCAN;
  assign tail_apply = tail.active && tail.phase == PH_APPLY;
  assign load_out   = res_pend && (!rsp_valid || rsp_ready);

  always_comb begin
    head_next        = head;
    head_next.active = 1'b0;
    if (accept && key != '0) begin
      head_next.active = 1'b1;
      head_next.phase  = PH_SCAN;
      head_next.cmd    = command;
      head_next.key    = key;
      head_next.qty    = quantity;
      head_next.found  = 1'b0;
      head_next.done   = 1'b0;
      head_next.count  = '0;
      head_next.total  = '0;
    end else if (tail_scan) begin
      // Scan result is known; send the request round again to act on it.
      head_next       = tail;
      head_next.phase = PH_APPLY;
      head_next.done  = 1'b0;
      head_next.count = '0;
      head_next.total = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && key == '0) begin
      res_count <= '0;
      res_found <= 1'b0;
      res_full  <= 1'b0;
      res_total <= running_total;
    end else if (tail_apply) begin
      res_count <= tail.count;
      res_found <= tail.found;
      res_full  <= (tail.cmd == CMD_ADD) && !tail.found && !tail.done;
      res_total <= tail.total;
    end
    if (load_out) begin
      count          <= res_count;
      found          <= res_found;
      table_full     <= res_full;
      total_quantity <= res_total;
    end
    if (rst) begin
      head          <= '0;
      busy          <= 1'b0;
      res_pend      <= 1'b0;
      rsp_valid     <= 1'b0;
      running_total <= '0;
    end else begin
      head <= head_next;
      if (accept && key != '0) begin
        busy <= 1'b1;
      end else if (tail_apply) begin
        busy <= 1'b0;
      end
      if (tail_apply) begin
        running_total <= tail.total;
      end
      if ((accept && key == '0) || tail_apply) begin
        res_pend <= 1'b1;
      end else if (load_out) begin
        res_pend <= 1'b0;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_one_request, $countones(act) <= 1, "more than one request in the chain")
  `ASSERT_NEXT(a_accept_busy, req_valid && req_ready, busy || res_pend, "request lost")
  `ASSERT_IMPLIES(a_total_ge, rsp_valid, total_quantity >= {{(TOTAL_W-COUNT_W){1'b0}}, count}, "total below count")
  `ASSERT_IMPLIES(a_full_shape, rsp_valid && table_full, !found && count == '0, "bad full response")

endmodule
`default_nettype wire

FILE: verif/keyed_quantity_table_checker.sv
// ---------------------------------------------------------------------------
// keyed_quantity_table_checker
// Watches both channels of the keyed quantity table. It keeps its own copy
// of the slot table, works out the reply for every accepted request and
// compares each accepted reply field by field with the oldest one owed.
// ---------------------------------------------------------------------------
module keyed_quantity_table_checker
  import kqt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   key,
  input  logic [COUNT_W-1:0] quantity,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  logic [COUNT_W-1:0] count,
  input  logic               found,
  input  logic               table_full,
  input  logic [TOTAL_W-1:0] total_quantity,
  output int                 mismatches,
  output int                 replies_owed
);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               found;
    logic               full;
    logic [TOTAL_W-1:0] total;
  } reply_t;

  logic [KEY_W-1:0]   slot_key   [KQT_ENTRIES];
  logic [COUNT_W-1:0] slot_count [KQT_ENTRIES];
  logic               slot_used  [KQT_ENTRIES];
  logic [TOTAL_W-1:0] sum_counts;
  reply_t             owed_replies[$];
  reply_t             want;

  // Applies one request to the shadow table and queues the reply it owes.
  function automatic void table_apply(input logic [CMD_W-1:0] cmd,
                                      input logic [KEY_W-1:0] k,
                                      input logic [COUNT_W-1:0] q);
    reply_t             r;
    int                 hit;
    int                 free_slot;
    logic [COUNT_W:0]   s;
    logic [TOTAL_W+5:0] acc;
    r = '0;
    hit = -1;
    free_slot = -1;
    if (k != '0) begin
      for (int i = 0; i < KQT_ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && slot_key[i] == k) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      r.found = (hit >= 0);
      case (kqt_cmd_t'(cmd))
        CMD_ADD: begin
          if (hit >= 0) begin
            s = {1'b0, slot_count[hit]} + {1'b0, q};
            slot_count[hit] = (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
            r.count = slot_count[hit];
          end else if (free_slot >= 0) begin
            slot_key[free_slot] = k;
            slot_count[free_slot] = q;
            slot_used[free_slot] = 1'b1;
            r.count = q;
          end else begin
            r.full = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (hit >= 0) begin
            if (q < slot_count[hit]) begin
              slot_count[hit] = slot_count[hit] - q;
              r.count = slot_count[hit];
            end else begin
              slot_used[hit] = 1'b0;
            end
          end
        end
        // Query, and the spare code, which acts as a query.
        default: begin
          if (hit >= 0) r.count = slot_count[hit];
        end
      endcase
      acc = '0;
      for (int i = 0; i < KQT_ENTRIES; i++) begin
        if (slot_used[i]) acc = acc + (TOTAL_W+6)'(slot_count[i]);
      end
      sum_counts = (acc > (TOTAL_W+6)'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOTAL_W-1:0];
    end
    r.total = sum_counts;
    owed_replies.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KQT_ENTRIES; i++) slot_used[i] = 1'b0;
      sum_counts = '0;
      owed_replies.delete();
    end else begin
      // Replies are checked before the request of the same edge is queued.
      if (rsp_valid && rsp_ready) begin
        if (owed_replies.size() == 0) begin
          $error("reply accepted with no request outstanding");
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            mismatches++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatches++;
          end
          if (table_full !== want.full) begin
            $error("table_full: expected %0d, got %0d", want.full, table_full);
            mismatches++;
          end
          if (total_quantity !== want.total) begin
            $error("total_quantity: expected %0d, got %0d", want.total, total_quantity);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) table_apply(command, key, quantity);
    end
    replies_owed = owed_replies.size();
  end

endmodule

FILE: verif/keyed_quantity_table_tb.sv
// ---------------------------------------------------------------------------
// keyed_quantity_table_tb
// Drives add, remove and query requests into the keyed quantity table and
// gives the verdict from the checker's mismatch count. A few directed
// requests hit the corner cases, then episodes fill the table from a key
// pool (overflowing it when the pool is large), mix random requests, and
// drain every key that was added.
// ---------------------------------------------------------------------------
module keyed_quantity_table_tb;
  import kqt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [CMD_W-1:0]   command = '0;
  logic [KEY_W-1:0]   key = '0;
  logic [COUNT_W-1:0] quantity = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [COUNT_W-1:0] count;
  logic               found;
  logic               table_full;
  logic [TOTAL_W-1:0] total_quantity;
  int                 mismatches;
  int                 replies_owed;

  bit idle_on = 1'b1;
  bit rsp_hold_req = 1'b0;
  bit added_keys [logic [KEY_W-1:0]];

  always #4 clk = ~clk;

  keyed_quantity_table uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .command(command), .key(key), .quantity(quantity),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .count(count), .found(found), .table_full(table_full),
    .total_quantity(total_quantity)
  );

  keyed_quantity_table_checker table_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .command(command), .key(key), .quantity(quantity),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .count(count), .found(found), .table_full(table_full),
    .total_quantity(total_quantity),
    .mismatches(mismatches), .replies_owed(replies_owed)
  );

  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                          input logic [COUNT_W-1:0] q);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 38) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    key <= k;
    quantity <= q;
    if (cmd == CMD_ADD && k != '0) added_keys[k] = 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic logic [COUNT_W-1:0] pick_qty();
    logic [COUNT_W-1:0] q;
    case ($urandom_range(3))
      0: q = COUNT_W'($urandom_range(15));
      1: q = COUNT_W'($urandom);
      2: q = COUNT_MAX - COUNT_W'($urandom_range(15));
      default: q = COUNT_W'($urandom_range(4095));
    endcase
    return q;
  endfunction

  // Receiver: random back-pressure, or a long hold when the stimulus asks.
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_hold_req = 1'b0;
      end else begin
        rsp_ready <= !(idle_on && $urandom_range(99) < 38);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("keyed_quantity_table_tb: done, errors");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0]   pool [40];
    int                 pool_n;
    logic [KEY_W-1:0]   cand;
    logic [KEY_W-1:0]   k;
    logic [CMD_W-1:0]   cmd;
    bit                 dup;
    int                 r;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed corner cases.
    send_req(CMD_QUERY, 16'd5, 24'd0);              // query on empty table
    send_req(CMD_ADD, 16'd0, COUNT_MAX);            // key zero is ignored
    send_req(CMD_REMOVE, 16'd7, 24'd3);             // remove of absent key
    send_req(CMD_ADD, 16'd1, 24'd0);                // new key with zero count
    send_req(CMD_ADD, 16'd1, COUNT_MAX);
    send_req(CMD_ADD, 16'd1, 24'd1);                // count saturates
    send_req(CMD_ADD, 16'hFFFF, 24'hABCDEF);
    send_req(CMD_SPARE, 16'hFFFF, COUNT_MAX);       // spare code acts as query
    send_req(CMD_QUERY, 16'd1, 24'h555555);
    send_req(CMD_REMOVE, 16'hFFFF, 24'd1);          // partial remove
    send_req(CMD_REMOVE, 16'hFFFF, COUNT_MAX);      // remove frees the slot
    send_req(CMD_REMOVE, 16'd1, COUNT_MAX);         // amount equal to count frees
    send_req(CMD_QUERY, 16'd0, 24'd0);
    send_req(CMD_REMOVE, 16'd0, 24'd1);

    for (int ep = 0; ep < 7; ep++) begin
      pool_n = (ep == 0) ? 40 : $urandom_range(20, 40);
      for (int i = 0; i < pool_n; i++) begin
        do begin
          cand = KEY_W'($urandom);
          dup = (cand == '0);
          for (int j = 0; j < i; j++) if (pool[j] == cand) dup = 1'b1;
        end while (dup);
        pool[i] = cand;
      end

      if (ep == 3) idle_on = 1'b0;

      // Fill: pools above the table size end in refused adds.
      for (int i = 0; i < pool_n; i++) send_req(CMD_ADD, pool[i], pick_qty());

      if (ep == 1) begin
        idle_on = 1'b0;
        rsp_hold_req = 1'b1;
      end
      if (ep == 2) begin
        @(negedge clk);
        req_valid <= 1'b0;
        wait (replies_owed == 0);
      end

      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(99);
        if (r < 45) cmd = CMD_ADD;
        else if (r < 70) cmd = CMD_REMOVE;
        else if (r < 95) cmd = CMD_QUERY;
        else cmd = CMD_SPARE;
        r = $urandom_range(99);
        if (r < 85) k = pool[$urandom_range(pool_n - 1)];
        else if (r < 97) k = KEY_W'($urandom);
        else k = '0;
        send_req(cmd, k, pick_qty());
      end
      if (ep == 1) idle_on = 1'b1;

      // Drain everything that was added so the next episode starts empty.
      foreach (added_keys[dk]) send_req(CMD_REMOVE, dk, COUNT_MAX);
      added_keys.delete();
      idle_on = 1'b1;
    end

    @(negedge clk);
    req_valid <= 1'b0;
    wait (replies_owed == 0);
    repeat (2 * KQT_ENTRIES + 8) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("keyed_quantity_table_tb: done, clean");
    end else begin
      $display("keyed_quantity_table_tb: done, errors");
    end
    $finish;
  end

endmodule
